FILE: hw/rtl/dvc_pkg.sv
package dvc_pkg;

   localparam int VALUE_W           = 32;
   localparam int OCC_W             = 7;
   localparam int OCC_MAX           = 127;
   localparam int DEFAULT_MAX_ITEMS = 64;

endpackage

FILE: hw/rtl/duplicate_value_counter.sv
// duplicate_value_counter
//
// Loads a list of signed 32-bit values, one transfer per cycle on the request
// side (start high while busy is low, req_last_item marks the final element).
// Elements beyond MAX_ITEMS are dropped and reported through rsp_overflow.
// After the final element the block goes busy and walks the stored list with
// one comparator and one store read port: for each position it reads the
// value, then scans the list from the start, counting equal entries and
// abandoning the position as soon as an equal value sits at an earlier place.
// Each repeated value is reported once, in order of first occurrence, with its
// total count. If nothing repeats, a single transfer with rsp_found low ends
// the run. rsp_last_result marks the final transfer of every run.
//
// Throughput: one element per cycle while loading. The report walk reads the
// stored list through the single store read port that feeds the comparator;
// busy stays high throughout.
// Results appear for exactly one cycle with rsp_valid; the receiver cannot
// stall them. Reset empties the list and clears the overflow flag; store
// contents need no clearing since only written entries are compared.
module duplicate_value_counter
   import dvc_pkg::*;
#(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_item,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic signed [VALUE_W-1:0] rsp_repeated_value,
   output logic [OCC_W-1:0]          rsp_occurrences,
   output logic                      rsp_overflow,
   output logic                      rsp_last_result
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_LATCH,
      S_SCAN,
      S_DRAIN
   } state_type;

   state_type                 state_ff;
   logic [VALUE_W-1:0]        store_mem [MAX_ITEMS];
   logic [VALUE_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]          rd_addr_in;
   logic                      wr_en_in;

   logic [CNT_W-1:0]          fill_ff;
   logic                      dropped_ff;
   logic [IDX_W-1:0]          i_ff;
   logic [IDX_W-1:0]          j_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [VALUE_W-1:0]        cur_ff;
   logic                      pend_valid_ff;
   logic [VALUE_W-1:0]        pend_value_ff;
   logic [OCC_W-1:0]          pend_occ_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [VALUE_W-1:0]        rsp_value_ff;
   logic [OCC_W-1:0]          rsp_occ_ff;
   logic                      rsp_overflow_ff;
   logic                      rsp_last_ff;

   logic                      accept;
   logic                      eq;
   logic                      is_before;
   logic                      j_last;
   logic                      i_last;
   logic                      emit;
   logic [CNT_W-1:0]          cnt_sum;
   logic [EXT_W-1:0]          cnt_ext;
   logic [OCC_W-1:0]          occ_sat;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign wr_en_in = accept && (fill_ff < CNT_W'(MAX_ITEMS));

   assign eq        = (rd_data_ff == cur_ff);
   assign is_before = (j_ff < i_ff);
   assign j_last    = ((CNT_W'(j_ff) + CNT_W'(1)) == fill_ff);
   assign i_last    = ((CNT_W'(i_ff) + CNT_W'(1)) == fill_ff);
   assign cnt_sum   = cnt_ff + CNT_W'(eq);
   assign cnt_ext   = EXT_W'(cnt_sum);
   assign occ_sat   = (cnt_ext > EXT_W'(OCC_MAX)) ? OCC_W'(OCC_MAX) : cnt_ext[OCC_W-1:0];
   assign emit      = j_last && !(eq && is_before) && (cnt_sum > CNT_W'(1));

   always_comb begin
      unique case (state_ff)
         S_FETCH: rd_addr_in = i_ff;
         S_LATCH: rd_addr_in = '0;
         S_SCAN:  rd_addr_in = j_ff + IDX_W'(1);
         default: rd_addr_in = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         store_mem[fill_ff[IDX_W-1:0]] <= req_value;
      end
      rd_data_ff <= store_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         cnt_ff        <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  if (wr_en_in) begin
                     fill_ff <= fill_ff + CNT_W'(1);
                  end else begin
                     dropped_ff <= 1'b1;
                  end
                  if (req_last_item) begin
                     i_ff          <= '0;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_LATCH;
            end
            S_LATCH: begin
               rsp_valid_ff <= 1'b0;
               cur_ff       <= rd_data_ff;
               j_ff         <= '0;
               cnt_ff       <= '0;
               state_ff     <= S_SCAN;
            end
            S_SCAN: begin
               rsp_valid_ff <= emit && pend_valid_ff;
               if ((eq && is_before) || j_last) begin
                  if (emit) begin
                     rsp_found_ff    <= 1'b1;
                     rsp_value_ff    <= pend_value_ff;
                     rsp_occ_ff      <= pend_occ_ff;
                     rsp_overflow_ff <= dropped_ff;
                     rsp_last_ff     <= 1'b0;
                     pend_valid_ff   <= 1'b1;
                     pend_value_ff   <= cur_ff;
                     pend_occ_ff     <= occ_sat;
                  end
                  if (i_last) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     i_ff     <= i_ff + IDX_W'(1);
                     state_ff <= S_FETCH;
                  end
               end else begin
                  cnt_ff <= cnt_sum;
                  j_ff   <= j_ff + IDX_W'(1);
               end
            end
            S_DRAIN: begin
               rsp_valid_ff    <= 1'b1;
               rsp_found_ff    <= pend_valid_ff;
               rsp_value_ff    <= pend_valid_ff ? pend_value_ff : '0;
               rsp_occ_ff      <= pend_valid_ff ? pend_occ_ff : '0;
               rsp_overflow_ff <= dropped_ff;
               rsp_last_ff     <= 1'b1;
               pend_valid_ff   <= 1'b0;
               fill_ff         <= '0;
               dropped_ff      <= 1'b0;
               state_ff        <= S_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_repeated_value = rsp_value_ff;
   assign rsp_occurrences    = rsp_occ_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_last_result    = rsp_last_ff;

   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("non-final result outside the report walk");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_occurrences >= OCC_W'(2))
      else $error("repeated value reported with count below two");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last_result)
      else $error("empty-run result not marked final");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_ITEMS))
      else $error("fill count beyond store depth");

   a_run_ends_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy && fill_ff == '0 && !dropped_ff)
      else $error("run did not return to an empty list");

endmodule

FILE: tb/dvc_report_checker.sv
module dvc_report_checker
   import dvc_pkg::*;
#(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_found,
   input  logic signed [VALUE_W-1:0] rsp_repeated_value,
   input  logic [OCC_W-1:0]          rsp_occurrences,
   input  logic                      rsp_overflow,
   input  logic                      rsp_last_result,
   output int                        fail_count,
   output int                        reports_pending,
   output int                        reports_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] value;
      logic [OCC_W-1:0]          occurrences;
      logic                      overflow;
      logic                      last_result;
   } dup_report_type;

   logic signed [VALUE_W-1:0] list_store [MAX_ITEMS];
   int                        list_len;
   bit                        list_dropped;
   dup_report_type            expected_reports [$];

   initial begin
      fail_count      = 0;
      reports_pending = 0;
      reports_seen    = 0;
      list_len        = 0;
      list_dropped    = 0;
   end

   function automatic void predict_duplicates();
      int             hits;
      int             made;
      bit             seen_earlier;
      dup_report_type rep;
      made = 0;
      for (int i = 0; i < list_len; i++) begin
         seen_earlier = 0;
         for (int j = 0; j < i; j++)
            if (list_store[j] == list_store[i]) seen_earlier = 1;
         if (!seen_earlier) begin
            hits = 0;
            for (int j = i; j < list_len; j++)
               if (list_store[j] == list_store[i]) hits++;
            if (hits > 1) begin
               rep.found       = 1'b1;
               rep.value       = list_store[i];
               rep.occurrences = OCC_W'((hits > OCC_MAX) ? OCC_MAX : hits);
               rep.overflow    = list_dropped;
               rep.last_result = 1'b0;
               expected_reports.push_back(rep);
               made++;
            end
         end
      end
      if (made == 0) begin
         rep.found       = 1'b0;
         rep.value       = '0;
         rep.occurrences = '0;
         rep.overflow    = list_dropped;
         rep.last_result = 1'b1;
         expected_reports.push_back(rep);
      end else begin
         expected_reports[$].last_result = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      dup_report_type want;
      dup_report_type got;
      if (reset) begin
         list_len     = 0;
         list_dropped = 0;
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            reports_seen++;
            got = '{rsp_found, rsp_repeated_value, rsp_occurrences, rsp_overflow,
                    rsp_last_result};
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected report found=%0b value=%0d occ=%0d ovf=%0b last=%0b",
                           $realtime, got.found, $signed(got.value), got.occurrences,
                           got.overflow, got.last_result);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: report mismatch", $realtime);
                     $display("   expected found=%0b value=%0d occ=%0d ovf=%0b last=%0b",
                              want.found, $signed(want.value), want.occurrences,
                              want.overflow, want.last_result);
                     $display("   actual   found=%0b value=%0d occ=%0d ovf=%0b last=%0b",
                              got.found, $signed(got.value), got.occurrences,
                              got.overflow, got.last_result);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (list_len < MAX_ITEMS) begin
               list_store[list_len] = req_value;
               list_len++;
            end else begin
               list_dropped = 1;
            end
            if (req_last_item) begin
               predict_duplicates();
               list_len     = 0;
               list_dropped = 0;
            end
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   import dvc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH  = DEFAULT_MAX_ITEMS;
   localparam int ITEM_TARGET = 430;
   localparam int QUIET_FROM  = 380;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_last_item;
   logic                      rsp_valid;
   logic                      rsp_found;
   logic signed [VALUE_W-1:0] rsp_repeated_value;
   logic [OCC_W-1:0]          rsp_occurrences;
   logic                      rsp_overflow;
   logic                      rsp_last_result;

   int fail_count;
   int reports_pending;
   int reports_seen;
   int items_sent;
   int lists_sent;
   int overflow_lists;

   duplicate_value_counter #(.MAX_ITEMS(LIST_DEPTH)) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_repeated_value (rsp_repeated_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result)
   );

   dvc_report_checker #(.MAX_ITEMS(LIST_DEPTH)) report_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_repeated_value (rsp_repeated_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result),
      .fail_count         (fail_count),
      .reports_pending    (reports_pending),
      .reports_seen       (reports_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

   task automatic send_element(input logic signed [VALUE_W-1:0] v, input bit last);
      @(negedge clock);
      start         <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (last) lists_sent++;
   endtask

   task automatic maybe_idle();
      int gap;
      if (items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         start         <= 1'b0;
         req_value     <= $urandom;
         req_last_item <= 1'($urandom_range(0, 1));
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_reports();
      @(negedge clock);
      start <= 1'b0;
      wait (reports_pending == 0);
   endtask

   task automatic send_list(input logic signed [VALUE_W-1:0] vals [$]);
      for (int k = 0; k < vals.size(); k++) begin
         maybe_idle();
         send_element(vals[k], k == vals.size() - 1);
      end
      if (vals.size() > LIST_DEPTH) overflow_lists++;
   endtask

   initial begin
      logic signed [VALUE_W-1:0] list [$];
      logic signed [VALUE_W-1:0] pool [4];
      logic signed [VALUE_W-1:0] wide_pool [32];
      logic signed [VALUE_W-1:0] corner [5];
      int run;
      int size;
      int mode;

      items_sent     = 0;
      lists_sent     = 0;
      overflow_lists = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_value      = '0;
      req_last_item  = 1'b0;
      corner         = '{VMIN, VMAX, 0, -1, 1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      list = '{0};
      send_list(list);
      list = '{VMIN, VMAX, -1, VMIN, 1, -1, VMAX, VMIN};
      send_list(list);
      list = '{5, 5, 5, 5};
      send_list(list);
      list = '{1, 2, 3, -1};
      send_list(list);
      list = '{7, 9, 7};
      send_list(list);
      drain_reports();

      run = 0;
      while (items_sent < ITEM_TARGET) begin
         run++;
         list.delete();
         for (int p = 0; p < 4; p++) pool[p] = $urandom;
         for (int p = 0; p < 32; p++) wide_pool[p] = $urandom;
         mode = $urandom_range(0, 2);
         case (run)
            2:       size = LIST_DEPTH + 1;
            6: begin
               size = LIST_DEPTH;
               mode = 3;
            end
            12:      size = LIST_DEPTH + 6;
            default: size = $urandom_range(1, 12);
         endcase
         for (int k = 0; k < size; k++) begin
            case (mode)
               0:       list.push_back(pool[$urandom_range(0, 3)]);
               1:       list.push_back(corner[$urandom_range(0, 4)]);
               2:       list.push_back($urandom);
               default: list.push_back(wide_pool[k % 32]);
            endcase
         end
         send_list(list);
         if (run % 4 == 0) drain_reports();
      end

      drain_reports();
      repeat (200) @(posedge clock);
      $display("%0d elements in %0d lists, %0d of them past the store depth",
               items_sent, lists_sent, overflow_lists);
      $display("%0d reports compared, %0d mismatches", reports_seen, fail_count);
      if (fail_count == 0 && reports_pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
